// ===== hw/rtl/dwc_pkg.sv =====
// dwc_pkg: types, codes, defaults and helpers for the depthwise conv stream core.
// No dependencies; used by the core, dwc_csr and dwc_checker.
package dwc_pkg;

   localparam int MAX_WIDTH_DEF    = 1024;
   localparam int MAX_KERNEL_DEF   = 5;
   localparam int MAX_DILATION_DEF = 2;

   localparam int RECIP_SHIFT = 20;

   typedef enum logic [1:0] {
      CMD_WEIGHT = 2'd0,
      CMD_BIAS   = 2'd1,
      CMD_PIXEL  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      REG_PLANE_WIDTH   = 3'd0,
      REG_KERNEL_WIDTH  = 3'd1,
      REG_KERNEL_HEIGHT = 3'd2,
      REG_DILATION_X    = 3'd3,
      REG_DILATION_Y    = 3'd4,
      REG_STEP_X        = 3'd5,
      REG_STEP_Y        = 3'd6,
      REG_RESULT_SHIFT  = 3'd7
   } reg_idx_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_DECIDE,
      ST_READ,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [10:0] plane_width;
      logic [2:0]  kernel_width;
      logic [2:0]  kernel_height;
      logic [1:0]  dilation_x;
      logic [1:0]  dilation_y;
      logic [2:0]  step_x;
      logic [2:0]  step_y;
      logic [4:0]  result_shift;
   } cfg_type;

   // floor(2^20 / d) + 1: exact quotient for 16-bit numerators, divisors 1..7
   function automatic logic [20:0] recip(input logic [2:0] d);
      logic [20:0] m;
      unique case (d)
         3'd2:    m = 21'd524289;
         3'd3:    m = 21'd349526;
         3'd4:    m = 21'd262145;
         3'd5:    m = 21'd209716;
         3'd6:    m = 21'd174763;
         3'd7:    m = 21'd149797;
         default: m = 21'd1048577;
      endcase
      return m;
   endfunction

endpackage

// ===== hw/rtl/depthwise_conv2d_stream_core.sv =====
// depthwise_conv2d_stream_core: weight/bias load beats leave the core idle and ready; a pixel
// beat with no window passes the check and decide states back to idle; a pixel that closes a
// window reads kw*kh taps, one tap read per cycle from the row store, drains the product and
// accumulate registers, then registers the result once any held result beat has left.
// Reset (synchronous) clears control state, weights and bias, then a clearing pass zeroes
// all SLOTS*2^clog2(MAX_WIDTH) row store words (9216 at defaults) with req_tready low.
module depthwise_conv2d_stream_core #(
   parameter int MAX_WIDTH    = dwc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_KERNEL   = dwc_pkg::MAX_KERNEL_DEF,
   parameter int MAX_DILATION = dwc_pkg::MAX_DILATION_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // tap_index[4:0], sample_value[20:5], bias_high[36:21]
   input  logic [1:0]  req_tuser,  // command[1:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // result_value[15:0], result_row[31:16], result_col[41:32]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SLOTS = MAX_DILATION * (MAX_KERNEL - 1) + 1;
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int AW    = SW + CW;
   localparam int DEPTH = SLOTS * (2 ** CW);
   localparam int TAPS  = MAX_KERNEL * MAX_KERNEL;
   localparam int WIW   = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int XW    = (CW + 1 > 11) ? CW + 1 : 11;
   localparam int ACCW  = 40;

   dwc_pkg::cfg_type cfg;

   dwc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // input fields
   logic [4:0]  tap;
   logic [15:0] low;
   logic [15:0] high;
   logic        accept;
   assign tap    = req_tdata[4:0];
   assign low    = req_tdata[20:5];
   assign high   = req_tdata[36:21];
   assign accept = req_tvalid && req_tready;

   dwc_pkg::state_type state_ff, state_in;

   logic [CW-1:0]  col_ff, col_in;
   logic [15:0]    row_ff, row_in;
   logic [SW-1:0]  head_ff, head_in;
   logic [AW-1:0]  clr_ff;

   logic signed [15:0] weights_ff [TAPS];
   logic [31:0]        bias_ff;

   // captured window job
   logic           win_ok_ff;
   logic [15:0]    xc_ff, xr_ff, qc_ff, qr_ff;
   logic [SW-1:0]  jhead_ff;
   logic [2:0]     kw_ff, kh_ff, dx_ff, dy_ff, sx_ff, sy_ff;
   logic [4:0]     ext_h_ff;

   // tap sequencer
   logic [2:0]     ti_ff, tj_ff;
   logic [SW-1:0]  slot_ff;
   logic [CW-1:0]  ccol_ff;
   logic [WIW-1:0] widx_ff;
   logic           v1_ff, v2_ff;
   logic signed [15:0]   w_ff;
   logic signed [31:0]   prod_ff;
   logic signed [ACCW-1:0] acc_ff;

   logic        rsp_valid_ff;
   logic [47:0] rsp_data_ff;

   // clamped geometry
   logic [XW-1:0] pw_c;
   logic [2:0]    kw_c, kh_c, dx_c, dy_c, sx_c, sy_c;
   logic [4:0]    ext_w, ext_h;
   logic [XW-1:0] col1;
   logic [16:0]   row1;
   logic          is_pixel;

   always_comb begin
      if (cfg.plane_width == 11'd0) pw_c = XW'(1);
      else if (XW'(cfg.plane_width) > XW'(MAX_WIDTH)) pw_c = XW'(MAX_WIDTH);
      else pw_c = XW'(cfg.plane_width);
      kw_c = (cfg.kernel_width == 3'd0) ? 3'd1 :
             (cfg.kernel_width > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : cfg.kernel_width;
      kh_c = (cfg.kernel_height == 3'd0) ? 3'd1 :
             (cfg.kernel_height > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : cfg.kernel_height;
      dx_c = (cfg.dilation_x == 2'd0) ? 3'd1 :
             ({1'b0, cfg.dilation_x} > 3'(MAX_DILATION)) ? 3'(MAX_DILATION)
                                                          : {1'b0, cfg.dilation_x};
      dy_c = (cfg.dilation_y == 2'd0) ? 3'd1 :
             ({1'b0, cfg.dilation_y} > 3'(MAX_DILATION)) ? 3'(MAX_DILATION)
                                                          : {1'b0, cfg.dilation_y};
      sx_c = (cfg.step_x == 3'd0) ? 3'd1 : cfg.step_x;
      sy_c = (cfg.step_y == 3'd0) ? 3'd1 : cfg.step_y;
      ext_w = 5'(dx_c) * 5'(kw_c - 3'd1) + 5'd1;
      ext_h = 5'(dy_c) * 5'(kh_c - 3'd1) + 5'd1;
      col1  = XW'(col_ff) + XW'(1);
      row1  = {1'b0, row_ff} + 17'd1;
   end

   assign is_pixel   = req_tuser == dwc_pkg::CMD_PIXEL;
   assign req_tready = state_ff == dwc_pkg::ST_IDLE;

   // quotient / remainder checks
   logic [36:0] pc, pr;
   logic        rem_zero;
   assign pc = 37'(xc_ff) * 37'(dwc_pkg::recip(sx_ff));
   assign pr = 37'(xr_ff) * 37'(dwc_pkg::recip(sy_ff));
   assign rem_zero = (xc_ff == 16'(qc_ff * 16'(sx_ff))) && (xr_ff == 16'(qr_ff * 16'(sy_ff)));

   // memory ports
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [15:0]   mem_wdata, mem_rdata;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = 16'd0;
      if (state_ff == dwc_pkg::ST_CLEAR) begin
         mem_we = 1'b1;
      end else if (accept && is_pixel) begin
         mem_we    = 1'b1;
         mem_waddr = {head_ff, col_ff};
         mem_wdata = low;
      end
   end

   assign mem_re    = state_ff == dwc_pkg::ST_READ;
   assign mem_raddr = {slot_ff, ccol_ff};

   dwc_row_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // window output values
   logic signed [ACCW-1:0] shifted;
   logic [15:0]            sat;
   logic                   out_free;
   assign shifted  = acc_ff >>> cfg.result_shift;
   assign out_free = !rsp_valid_ff || rsp_tready;
   always_comb begin
      if (shifted > ACCW'(32767)) sat = 16'h7FFF;
      else if (shifted < -ACCW'(32768)) sat = 16'h8000;
      else sat = shifted[15:0];
   end

   logic last_tap;
   assign last_tap = (tj_ff == kw_ff - 3'd1) && (ti_ff == kh_ff - 3'd1);

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      head_in  = head_ff;
      unique case (state_ff)
         dwc_pkg::ST_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) state_in = dwc_pkg::ST_IDLE;
         end
         dwc_pkg::ST_IDLE: begin
            if (accept && is_pixel) begin
               state_in = dwc_pkg::ST_CHECK;
               if (req_tlast) begin
                  col_in  = '0;
                  row_in  = '0;
                  head_in = '0;
               end else if (col1 >= pw_c) begin
                  col_in  = '0;
                  row_in  = row_ff + 16'd1;
                  head_in = (32'(head_ff) == SLOTS - 1) ? '0 : head_ff + SW'(1);
               end else begin
                  col_in = col_ff + CW'(1);
               end
            end
         end
         dwc_pkg::ST_CHECK:  state_in = dwc_pkg::ST_DECIDE;
         dwc_pkg::ST_DECIDE: state_in = (win_ok_ff && rem_zero) ? dwc_pkg::ST_READ
                                                                : dwc_pkg::ST_IDLE;
         dwc_pkg::ST_READ:   if (last_tap) state_in = dwc_pkg::ST_DRAIN;
         dwc_pkg::ST_DRAIN:  if (!v1_ff && !v2_ff) state_in = dwc_pkg::ST_FINISH;
         dwc_pkg::ST_FINISH: if (out_free) state_in = dwc_pkg::ST_IDLE;
         default:            state_in = dwc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dwc_pkg::ST_CLEAR;
         col_ff       <= '0;
         row_ff       <= '0;
         head_ff      <= '0;
         clr_ff       <= '0;
         bias_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         for (int k = 0; k < TAPS; k++) weights_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         head_ff  <= head_in;
         if (state_ff == dwc_pkg::ST_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (accept && req_tuser == dwc_pkg::CMD_WEIGHT && 6'(tap) < 6'(TAPS))
            weights_ff[WIW'(tap)] <= low;
         if (accept && req_tuser == dwc_pkg::CMD_BIAS) bias_ff <= {high, low};
         v1_ff <= state_ff == dwc_pkg::ST_READ;
         v2_ff <= v1_ff;
         if (state_ff == dwc_pkg::ST_FINISH && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath registers
   logic [5:0] back6, head6;
   logic [5:0] slot_step;
   assign back6     = 6'(ext_h_ff) - 6'd1;
   assign head6     = 6'(jhead_ff);
   assign slot_step = 6'(slot_ff) + 6'(dy_ff);

   always_ff @(posedge clock) begin
      if (state_ff == dwc_pkg::ST_IDLE && accept && is_pixel) begin
         win_ok_ff <= (col1 >= XW'(ext_w)) && (row1 >= 17'(ext_h));
         xc_ff     <= 16'(col1 - XW'(ext_w));
         xr_ff     <= 16'(row1 - 17'(ext_h));
         jhead_ff  <= head_ff;
         kw_ff     <= kw_c;
         kh_ff     <= kh_c;
         dx_ff     <= dx_c;
         dy_ff     <= dy_c;
         sx_ff     <= sx_c;
         sy_ff     <= sy_c;
         ext_h_ff  <= ext_h;
      end
      if (state_ff == dwc_pkg::ST_CHECK) begin
         qc_ff <= pc[35:20];
         qr_ff <= pr[35:20];
      end
      if (state_ff == dwc_pkg::ST_DECIDE) begin
         ti_ff   <= '0;
         tj_ff   <= '0;
         widx_ff <= '0;
         ccol_ff <= xc_ff[CW-1:0];
         slot_ff <= (head6 >= back6) ? SW'(head6 - back6) : SW'(head6 + 6'(SLOTS) - back6);
         acc_ff  <= ACCW'($signed(bias_ff));
      end
      if (state_ff == dwc_pkg::ST_READ) begin
         w_ff    <= weights_ff[widx_ff];
         widx_ff <= widx_ff + WIW'(1);
         if (tj_ff == kw_ff - 3'd1) begin
            tj_ff   <= '0;
            ti_ff   <= ti_ff + 3'd1;
            ccol_ff <= xc_ff[CW-1:0];
            slot_ff <= (slot_step >= 6'(SLOTS)) ? SW'(slot_step - 6'(SLOTS)) : SW'(slot_step);
         end else begin
            tj_ff   <= tj_ff + 3'd1;
            ccol_ff <= ccol_ff + CW'(dx_ff);
         end
      end
      if (v1_ff) prod_ff <= $signed(mem_rdata) * w_ff;
      if (v2_ff) acc_ff <= acc_ff + ACCW'(prod_ff);
      if (state_ff == dwc_pkg::ST_FINISH && out_free)
         rsp_data_ff <= {6'd0, qc_ff[9:0], qr_ff, sat};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hw/rtl/dwc_csr.sv =====
// dwc_csr: APB-style register bank holding the convolution geometry and shift.
// Depends on dwc_pkg.
module dwc_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output dwc_pkg::cfg_type cfg
);

   dwc_pkg::cfg_type cfg_ff;
   dwc_pkg::reg_idx_type idx;
   logic wr;

   assign pready = 1'b1;
   assign idx    = dwc_pkg::reg_idx_type'(paddr[4:2]);
   assign wr     = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.plane_width   <= 11'd1;
         cfg_ff.kernel_width  <= 3'd3;
         cfg_ff.kernel_height <= 3'd3;
         cfg_ff.dilation_x    <= 2'd1;
         cfg_ff.dilation_y    <= 2'd1;
         cfg_ff.step_x        <= 3'd1;
         cfg_ff.step_y        <= 3'd1;
         cfg_ff.result_shift  <= 5'd8;
      end else if (wr) begin
         unique case (idx)
            dwc_pkg::REG_PLANE_WIDTH:   cfg_ff.plane_width   <= pwdata[10:0];
            dwc_pkg::REG_KERNEL_WIDTH:  cfg_ff.kernel_width  <= pwdata[2:0];
            dwc_pkg::REG_KERNEL_HEIGHT: cfg_ff.kernel_height <= pwdata[2:0];
            dwc_pkg::REG_DILATION_X:    cfg_ff.dilation_x    <= pwdata[1:0];
            dwc_pkg::REG_DILATION_Y:    cfg_ff.dilation_y    <= pwdata[1:0];
            dwc_pkg::REG_STEP_X:        cfg_ff.step_x        <= pwdata[2:0];
            dwc_pkg::REG_STEP_Y:        cfg_ff.step_y        <= pwdata[2:0];
            dwc_pkg::REG_RESULT_SHIFT:  cfg_ff.result_shift  <= pwdata[4:0];
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         dwc_pkg::REG_PLANE_WIDTH:   prdata = {21'd0, cfg_ff.plane_width};
         dwc_pkg::REG_KERNEL_WIDTH:  prdata = {29'd0, cfg_ff.kernel_width};
         dwc_pkg::REG_KERNEL_HEIGHT: prdata = {29'd0, cfg_ff.kernel_height};
         dwc_pkg::REG_DILATION_X:    prdata = {30'd0, cfg_ff.dilation_x};
         dwc_pkg::REG_DILATION_Y:    prdata = {30'd0, cfg_ff.dilation_y};
         dwc_pkg::REG_STEP_X:        prdata = {29'd0, cfg_ff.step_x};
         dwc_pkg::REG_STEP_Y:        prdata = {29'd0, cfg_ff.step_y};
         dwc_pkg::REG_RESULT_SHIFT:  prdata = {27'd0, cfg_ff.result_shift};
      endcase
   end

endmodule

// ===== hw/rtl/dwc_row_store.sv =====
// dwc_row_store: single-port-write, single-port-read pixel memory, registered read.
// Depends on nothing; address is {ring slot, column}.
module dwc_row_store #(
   parameter int DEPTH = 9216,
   parameter int AW    = 14
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/dwc_checker.sv =====
// dwc_checker: port-level checks for depthwise_conv2d_stream_core, bound to the top level.
// Depends on dwc_pkg.
module dwc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // held result beat stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed while stalled");

   // clearing pass blocks input straight after reset
   assert property (@(posedge clock)
      $past(reset) |-> !req_tready)
      else $error("input ready during row store clear");

   // an accepted pixel beat drops the input ready straight after it is taken
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == dwc_pkg::CMD_PIXEL |=> !req_tready)
      else $error("input reopened during pixel work");

   // no result appears the cycle after any accepted beat
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result raised too early");

endmodule

bind depthwise_conv2d_stream_core dwc_checker u_dwc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
